// ===== design/sscsd_pkg.sv =====
// Shared constants, types and lookup functions of the seven-segment clock scan driver.
`default_nettype none

package sscsd_pkg;

  localparam int NUM_DIGITS         = 6;
  localparam int LAST_POS           = NUM_DIGITS - 1;
  localparam int TICK_COUNTER_WIDTH = 16;

  localparam int POS_W      = 3;
  localparam int DIGIT_W    = 4;
  localparam int SEG_W      = 7;
  localparam int DUTY_W     = 7;
  localparam int BRIGHT_W   = 7;
  localparam int INTERVAL_W = 16;
  localparam int SCALE_W    = 20;
  localparam int PROD_W     = BRIGHT_W + SCALE_W;
  localparam int DUTY_SHIFT = 19;
  localparam int CMP_W      = 32;

  localparam logic [BRIGHT_W-1:0]   BRIGHT_MAX      = 7'd100;
  localparam logic [BRIGHT_W-1:0]   BRIGHT_RESET    = 7'd100;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET  = 16'd1;
  localparam logic [4:0]            HOUR_MAX        = 5'd23;
  localparam logic [5:0]            MINUTE_MAX      = 6'd59;

  typedef enum logic {
    REG_BRIGHTNESS      = 1'b0,
    REG_SWITCH_INTERVAL = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic [BRIGHT_W-1:0]   brightness;
    logic [INTERVAL_W-1:0] switch_interval;
  } cfg_t;

  typedef struct packed {
    logic [POS_W-1:0]   pos;
    logic [DIGIT_W-1:0] digit;
  } scan_view_t;

  // Standard segment pattern; a code above nine is shown as zero.
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] p;
    case (d)
      4'd0:    p = 7'h3F;
      4'd1:    p = 7'h06;
      4'd2:    p = 7'h5B;
      4'd3:    p = 7'h4F;
      4'd4:    p = 7'h66;
      4'd5:    p = 7'h6D;
      4'd6:    p = 7'h7D;
      4'd7:    p = 7'h07;
      4'd8:    p = 7'h7F;
      4'd9:    p = 7'h6F;
      default: p = 7'h3F;
    endcase
    return p;
  endfunction

  // Compensation (lit segments * 100 / 7) pre-multiplied by 5243, so that
  // brightness * scale >> 19 equals brightness * compensation / 100 exactly.
  function automatic logic [SCALE_W-1:0] duty_scale(input logic [DIGIT_W-1:0] d);
    logic [SCALE_W-1:0] k;
    case (d)
      4'd0:    k = 20'd445655;
      4'd1:    k = 20'd146804;
      4'd2:    k = 20'd372253;
      4'd3:    k = 20'd372253;
      4'd4:    k = 20'd298851;
      4'd5:    k = 20'd372253;
      4'd6:    k = 20'd445655;
      4'd7:    k = 20'd220206;
      4'd8:    k = 20'd524300;
      4'd9:    k = 20'd445655;
      default: k = 20'd445655;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== design/seven_segment_clock_scan_driver.sv =====
// Top level of the six-digit seven-segment clock scan driver.
`default_nettype none

// Each accepted item (a tick or a set-time request) is processed in the cycle
// it is accepted, and its result is offered on the next cycle; one item can be
// accepted every cycle unless the output stalls, the rate set by the update
// of the tick counter and scan position. The input is ready whenever no result
// is pending or the pending result is being taken in the same cycle. The block
// has no memories and needs no clearing pass after reset. Register 0 at byte
// address 0 is brightness, register 1 at byte address 4 is the switch interval.
module seven_segment_clock_scan_driver #(
  parameter int TICK_COUNTER_WIDTH = sscsd_pkg::TICK_COUNTER_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            req_type,
  input  logic [4:0]                      hours,
  input  logic [5:0]                      minutes,
  input  logic [5:0]                      seconds,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sscsd_pkg::POS_W-1:0]     digit_select,
  output logic [sscsd_pkg::SEG_W-1:0]     segment_lines,
  output logic [sscsd_pkg::DUTY_W-1:0]    segment_duty
);
  import sscsd_pkg::*;

  cfg_t       cfg;
  scan_view_t view;
  logic       fire;

  assign fire = in_valid && in_ready;

  sscsd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sscsd_scan #(
    .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
  ) u_scan (
    .clk             (clk),
    .rst             (rst),
    .fire            (fire),
    .req_type        (req_type),
    .hours           (hours),
    .minutes         (minutes),
    .seconds         (seconds),
    .switch_interval (cfg.switch_interval),
    .view            (view)
  );

  sscsd_out u_out (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .view          (view),
    .brightness    (cfg.brightness),
    .digit_select  (digit_select),
    .segment_lines (segment_lines),
    .segment_duty  (segment_duty)
  );

`ifndef NO_ASSERTIONS
  a_dark_at_zero_duty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && segment_duty == '0) |-> (segment_lines == '0))
    else $error("segments lit at zero duty");

  a_duty_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (segment_duty <= DUTY_W'(100)))
    else $error("duty above one hundred percent");

  a_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    (fire && !$past(rst)) |=> out_valid)
    else $error("accepted item produced no result");
`endif

endmodule

`default_nettype wire

// ===== design/sscsd_regs.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none

module sscsd_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output sscsd_pkg::cfg_t     cfg
);
  import sscsd_pkg::*;

  reg_sel_t            sel;
  logic                wr_en;
  logic [BRIGHT_W-1:0] bright_in;

  assign pready    = 1'b1;
  assign sel       = reg_sel_t'(paddr[2]);
  assign wr_en     = psel && penable && pwrite && pready;
  assign bright_in = (pwdata[BRIGHT_W-1:0] > BRIGHT_MAX) ? BRIGHT_MAX : pwdata[BRIGHT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brightness      <= BRIGHT_RESET;
      cfg.switch_interval <= INTERVAL_RESET;
    end else if (wr_en) begin
      unique case (sel)
        REG_BRIGHTNESS:      cfg.brightness      <= bright_in;
        REG_SWITCH_INTERVAL: cfg.switch_interval <= pwdata[INTERVAL_W-1:0];
        default:             ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_BRIGHTNESS:      prdata = 32'(cfg.brightness);
      REG_SWITCH_INTERVAL: prdata = 32'(cfg.switch_interval);
      default:             prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/sscsd_scan.sv =====
// Digit store, tick counter and scan position, updated once per accepted item.
`default_nettype none

module sscsd_scan #(
  parameter int TICK_COUNTER_WIDTH = sscsd_pkg::TICK_COUNTER_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               fire,
  input  logic                               req_type,
  input  logic [4:0]                         hours,
  input  logic [5:0]                         minutes,
  input  logic [5:0]                         seconds,
  input  logic [sscsd_pkg::INTERVAL_W-1:0]   switch_interval,
  output sscsd_pkg::scan_view_t              view
);
  import sscsd_pkg::*;

  // Splits a value of at most 59 into its tens and units digits.
  function automatic logic [2*DIGIT_W-1:0] split_tens(input logic [5:0] v);
    logic [DIGIT_W-1:0] tens;
    logic [5:0]         base;
    if (v >= 6'd50) begin
      tens = 4'd5; base = 6'd50;
    end else if (v >= 6'd40) begin
      tens = 4'd4; base = 6'd40;
    end else if (v >= 6'd30) begin
      tens = 4'd3; base = 6'd30;
    end else if (v >= 6'd20) begin
      tens = 4'd2; base = 6'd20;
    end else if (v >= 6'd10) begin
      tens = 4'd1; base = 6'd10;
    end else begin
      tens = 4'd0; base = 6'd0;
    end
    return {tens, 4'(v - base)};
  endfunction

  logic [DIGIT_W-1:0]            digit_store [NUM_DIGITS];
  logic [POS_W-1:0]              scan_position;
  logic [TICK_COUNTER_WIDTH-1:0] tick_count;
  logic [DIGIT_W-1:0]            shown_digit;

  logic [TICK_COUNTER_WIDTH-1:0] tick_inc;
  logic                          advance;
  logic [POS_W-1:0]              pos_adv;
  logic [4:0]                    hours_c;
  logic [5:0]                    minutes_c;
  logic [5:0]                    seconds_c;
  logic [2*DIGIT_W-1:0]          h_split;
  logic [2*DIGIT_W-1:0]          m_split;
  logic [2*DIGIT_W-1:0]          s_split;

  assign tick_inc  = tick_count + 1'b1;
  assign advance   = CMP_W'(tick_inc) >= CMP_W'(switch_interval);
  assign pos_adv   = (scan_position == POS_W'(LAST_POS)) ? '0 : scan_position + 1'b1;
  assign hours_c   = (hours > HOUR_MAX) ? HOUR_MAX : hours;
  assign minutes_c = (minutes > MINUTE_MAX) ? MINUTE_MAX : minutes;
  assign seconds_c = (seconds > MINUTE_MAX) ? MINUTE_MAX : seconds;
  assign h_split   = split_tens({1'b0, hours_c});
  assign m_split   = split_tens(minutes_c);
  assign s_split   = split_tens(seconds_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_store[i] <= '0;
      end
      scan_position <= '0;
      tick_count    <= '0;
      shown_digit   <= '0;
    end else if (fire) begin
      if (req_type) begin
        digit_store[0] <= h_split[2*DIGIT_W-1:DIGIT_W];
        digit_store[1] <= h_split[DIGIT_W-1:0];
        digit_store[2] <= m_split[2*DIGIT_W-1:DIGIT_W];
        digit_store[3] <= m_split[DIGIT_W-1:0];
        digit_store[4] <= s_split[2*DIGIT_W-1:DIGIT_W];
        digit_store[5] <= s_split[DIGIT_W-1:0];
      end else if (advance) begin
        tick_count    <= '0;
        scan_position <= pos_adv;
        shown_digit   <= digit_store[pos_adv];
      end else begin
        tick_count <= tick_inc;
      end
    end
  end

  assign view.pos   = scan_position;
  assign view.digit = shown_digit;

`ifndef NO_ASSERTIONS
  a_pos_held_when_idle: assert property (@(posedge clk) disable iff (rst)
    (!$past(fire) && !$past(rst)) |-> $stable(scan_position))
    else $error("scan position moved without an accepted item");

  a_set_keeps_scan: assert property (@(posedge clk) disable iff (rst)
    ($past(fire) && $past(req_type) && !$past(rst)) |->
      ($stable(scan_position) && $stable(shown_digit) && $stable(tick_count)))
    else $error("set-time item disturbed the scan state");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    scan_position <= POS_W'(LAST_POS))
    else $error("scan position beyond the last digit");

  a_digit_decimal: assert property (@(posedge clk) disable iff (rst)
    shown_digit <= 4'd9)
    else $error("latched digit is not decimal");
`endif

endmodule

`default_nettype wire

// ===== design/sscsd_out.sv =====
// Result handshake and segment mask and duty formatting for the shown digit.
`default_nettype none

module sscsd_out (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             fire,
  output logic                             in_ready,
  output logic                             out_valid,
  input  logic                             out_ready,
  input  sscsd_pkg::scan_view_t            view,
  input  logic [sscsd_pkg::BRIGHT_W-1:0]   brightness,
  output logic [sscsd_pkg::POS_W-1:0]      digit_select,
  output logic [sscsd_pkg::SEG_W-1:0]      segment_lines,
  output logic [sscsd_pkg::DUTY_W-1:0]     segment_duty
);
  import sscsd_pkg::*;

  logic [SEG_W-1:0]  pattern;
  logic [SEG_W-1:0]  mask;
  logic [PROD_W-1:0] product;
  logic [DUTY_W-1:0] duty;

  // The scan state registers always hold the pending result, so only the
  // valid flag is kept here.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= fire || (out_valid && !out_ready);
    end
  end

  assign in_ready = !out_valid || out_ready;

  assign pattern = seg_pattern(view.digit);
  assign product = PROD_W'(brightness) * PROD_W'(duty_scale(view.digit));
  assign duty    = product[DUTY_SHIFT+DUTY_W-1:DUTY_SHIFT];

  // The last position is wired with segments F and G exchanged.
  always_comb begin
    mask = pattern;
    if (view.pos == POS_W'(LAST_POS)) begin
      mask[5] = pattern[6];
      mask[6] = pattern[5];
    end
    if (duty == '0) begin
      mask = '0;
    end
  end

  assign digit_select  = view.pos;
  assign segment_lines = mask;
  assign segment_duty  = duty;

endmodule

`default_nettype wire
